>>> rtl/fixed_point_alu_defines.svh
// Assertion macros shared by the checker of the fixed-point arithmetic unit.
// No dependencies; included by the checker file only.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fixed_point_alu check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fixed_point_alu check failed");

`endif

>>> rtl/fpa_pkg.sv
// Shared types, constants and helpers of the fixed-point arithmetic unit.
// No dependencies.
`default_nettype none

package fpa_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned MaxFrac      = 16;
  localparam logic [4:0]  FracReset    = 5'd14;

  // Operation codes carried in the input tuser.
  typedef enum logic [4:0] {
    OP_OFINT    = 5'd0,
    OP_TRUNC    = 5'd1,
    OP_ROUND    = 5'd2,
    OP_REFORMAT = 5'd3,
    OP_ADD      = 5'd4,
    OP_SUB      = 5'd5,
    OP_NEG      = 5'd6,
    OP_MUL      = 5'd7,
    OP_DIV      = 5'd8,
    OP_INV      = 5'd9,
    OP_ADDI     = 5'd10,
    OP_SUBI     = 5'd11,
    OP_MULI     = 5'd12,
    OP_DIVI     = 5'd13,
    OP_INVI     = 5'd14,
    OP_ISUB     = 5'd15,
    OP_IDIV     = 5'd16,
    OP_IDIVI    = 5'd17
  } op_e;

  // Control that travels alongside the divider data.
  typedef struct packed {
    logic neg;  // quotient must be negated
    logic dz;   // divisor was zero
  } ctl_t;

  // Fraction sizes above the supported maximum saturate.
  function automatic logic [4:0] clamp_frac(logic [4:0] v);
    return (v > 5'(MaxFrac)) ? 5'(MaxFrac) : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fpa_front.sv
// Front end: operand capture with the multiplier, operation decode into a
// dividend and divisor, then conversion to magnitudes. Uses fpa_pkg.
`default_nettype none

module fpa_front #(
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         en_i,
  input  wire                                         valid_i,
  input  wire  [4:0]                                  op_i,
  input  wire  [31:0]                                 a_i,
  input  wire  [31:0]                                 b_i,
  input  wire  [4:0]                                  frac_i,
  input  wire  [4:0]                                  tfrac_i,
  output logic                                        valid_o,
  output logic [DATA_WIDTH+2*fpa_pkg::MaxFrac-1:0]    n_mag_o,
  output logic [DATA_WIDTH:0]                         d_mag_o,
  output fpa_pkg::ctl_t                               ctl_o
);

  localparam int unsigned NW  = DATA_WIDTH + 2 * fpa_pkg::MaxFrac;
  localparam int unsigned DVW = DATA_WIDTH + 1;

  // Stage 1: operands cut to the data width, product formed.
  logic signed [DATA_WIDTH-1:0]   a_in, b_in;
  logic signed [2*DATA_WIDTH-1:0] prod_d;
  logic                           v1_q;
  fpa_pkg::op_e                   op1_q;
  logic signed [DATA_WIDTH-1:0]   a1_q, b1_q;
  logic [4:0]                     q1_q, t1_q;
  logic signed [2*DATA_WIDTH-1:0] prod1_q;

  assign a_in   = a_i[DATA_WIDTH-1:0];
  assign b_in   = b_i[DATA_WIDTH-1:0];
  assign prod_d = a_in * b_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= fpa_pkg::op_e'(op_i);
      a1_q    <= a_in;
      b1_q    <= b_in;
      q1_q    <= fpa_pkg::clamp_frac(frac_i);
      t1_q    <= fpa_pkg::clamp_frac(tfrac_i);
      prod1_q <= prod_d;
    end
  end

  // Stage 2: dividend and divisor chosen by the operation.
  logic signed [NW-1:0] ae, be, pe, fe, half, n2_d;
  logic [5:0]           q2;
  logic [DVW-1:0]       ax, bx, amag, bmag, fmag, dmag_d;
  logic                 dneg_d, dz_d;
  logic                 v2_q;
  logic signed [NW-1:0] n2_q;
  logic [DVW-1:0]       dmag2_q;
  logic                 dneg2_q, dz2_q;

  always_comb begin
    ae     = NW'(a1_q);
    be     = NW'(b1_q);
    pe     = NW'(prod1_q);
    q2     = {q1_q, 1'b0};
    fe     = NW'(1) << q1_q;
    half   = fe >>> 1;
    ax     = DVW'(a1_q);
    bx     = DVW'(b1_q);
    amag   = a1_q[DATA_WIDTH-1] ? DVW'(0) - ax : ax;
    bmag   = b1_q[DATA_WIDTH-1] ? DVW'(0) - bx : bx;
    fmag   = DVW'(1) << q1_q;
    n2_d   = '0;
    dmag_d = DVW'(1);
    dneg_d = 1'b0;
    dz_d   = 1'b0;
    unique case (op1_q) inside
      fpa_pkg::OP_OFINT: n2_d = ae <<< q1_q;
      fpa_pkg::OP_TRUNC: begin
        n2_d   = ae;
        dmag_d = fmag;
      end
      fpa_pkg::OP_ROUND: begin
        n2_d   = a1_q[DATA_WIDTH-1] ? ae - half : ae + half;
        dmag_d = fmag;
      end
      fpa_pkg::OP_REFORMAT: begin
        n2_d   = ae <<< t1_q;
        dmag_d = fmag;
      end
      fpa_pkg::OP_ADD:  n2_d = ae + be;
      fpa_pkg::OP_SUB:  n2_d = ae - be;
      fpa_pkg::OP_NEG:  n2_d = NW'(0) - ae;
      fpa_pkg::OP_MUL: begin
        n2_d   = pe;
        dmag_d = fmag;
      end
      fpa_pkg::OP_DIV, fpa_pkg::OP_IDIVI: begin
        n2_d   = ae <<< q1_q;
        dmag_d = bmag;
        dneg_d = b1_q[DATA_WIDTH-1];
        dz_d   = (b1_q == '0);
      end
      fpa_pkg::OP_INV: begin
        n2_d   = NW'(1) << q2;
        dmag_d = amag;
        dneg_d = a1_q[DATA_WIDTH-1];
        dz_d   = (a1_q == '0);
      end
      fpa_pkg::OP_ADDI: n2_d = ae + (be <<< q1_q);
      fpa_pkg::OP_SUBI: n2_d = ae - (be <<< q1_q);
      fpa_pkg::OP_MULI: n2_d = pe;
      fpa_pkg::OP_DIVI: begin
        n2_d   = ae;
        dmag_d = bmag;
        dneg_d = b1_q[DATA_WIDTH-1];
        dz_d   = (b1_q == '0);
      end
      fpa_pkg::OP_INVI: begin
        n2_d   = fe;
        dmag_d = amag;
        dneg_d = a1_q[DATA_WIDTH-1];
        dz_d   = (a1_q == '0);
      end
      fpa_pkg::OP_ISUB: n2_d = (ae <<< q1_q) - be;
      fpa_pkg::OP_IDIV: begin
        n2_d   = ae <<< q2;
        dmag_d = bmag;
        dneg_d = b1_q[DATA_WIDTH-1];
        dz_d   = (b1_q == '0);
      end
      default: n2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q    <= n2_d;
      dmag2_q <= dmag_d;
      dneg2_q <= dneg_d;
      dz2_q   <= dz_d;
    end
  end

  // Stage 3: dividend magnitude and quotient sign.
  logic          v3_q;
  logic [NW-1:0] nmag3_q;
  logic [DVW-1:0] dmag3_q;
  fpa_pkg::ctl_t ctl3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag3_q    <= n2_q[NW-1] ? NW'(0) - NW'(n2_q) : NW'(n2_q);
      dmag3_q    <= dmag2_q;
      ctl3_q.neg <= n2_q[NW-1] ^ dneg2_q;
      ctl3_q.dz  <= dz2_q;
    end
  end

  assign valid_o = v3_q;
  assign n_mag_o = nmag3_q;
  assign d_mag_o = dmag3_q;
  assign ctl_o   = ctl3_q;

endmodule

`default_nettype wire

>>> rtl/fpa_divider.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Uses fpa_pkg for the control struct.
`default_nettype none

module fpa_divider #(
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        en_i,
  input  wire                                        valid_i,
  input  wire  [DATA_WIDTH+2*fpa_pkg::MaxFrac-1:0]   n_i,
  input  wire  [DATA_WIDTH:0]                        d_i,
  input  wire  fpa_pkg::ctl_t                        ctl_i,
  output logic                                       valid_o,
  output logic [DATA_WIDTH+2*fpa_pkg::MaxFrac-1:0]   quo_o,
  output fpa_pkg::ctl_t                              ctl_o
);

  localparam int unsigned NW  = DATA_WIDTH + 2 * fpa_pkg::MaxFrac;
  localparam int unsigned DVW = DATA_WIDTH + 1;

  // Index 0 is the input; index k holds the state after k quotient bits.
  logic                v_s   [NW+1];
  logic [NW-1:0]       n_s   [NW+1];
  logic [DVW-1:0]      rem_s [NW+1];
  logic [DVW-1:0]      d_s   [NW+1];
  fpa_pkg::ctl_t       ctl_s [NW+1];

  assign v_s[0]   = valid_i;
  assign n_s[0]   = n_i;
  assign rem_s[0] = '0;
  assign d_s[0]   = d_i;
  assign ctl_s[0] = ctl_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DVW:0]   trial, diff;
    logic           ge;
    logic [DVW-1:0] rem_d;

    // Bring down the next dividend bit and try a subtraction.
    always_comb begin
      trial = {rem_s[k], n_s[k][NW-1]};
      diff  = trial - {1'b0, d_s[k]};
      ge    = ~diff[DVW];
      rem_d = ge ? diff[DVW-1:0] : trial[DVW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    // The dividend register fills with quotient bits from the bottom.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_s[k+1]   <= {n_s[k][NW-2:0], ge};
        rem_s[k+1] <= rem_d;
        d_s[k+1]   <= d_s[k];
        ctl_s[k+1] <= ctl_s[k];
      end
    end
  end

  assign valid_o = v_s[NW];
  assign quo_o   = n_s[NW];
  assign ctl_o   = ctl_s[NW];

endmodule

`default_nettype wire

>>> rtl/fixed_point_alu.sv
// Each transaction passes through the front-end stages, the divider stages and the output register.
// Throughput: one transaction per cycle while the output is not stalled; the divider has one stage per
// dividend bit (DATA_WIDTH + 32 stages) and every operation passes through it.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and loads frac_bits with 14.
`default_nettype none

module fixed_point_alu #(
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: frac_bits
  input  wire         cfg_we_i,
  input  wire  [4:0]  cfg_wdata_i,
  // Input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32], target_frac_bits[68:64]
  input  wire  [4:0]  s_axis_tuser,  // opcode[4:0]
  // Output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result[31:0]
  output logic        m_axis_tuser   // divide_by_zero[0]
);

  localparam int unsigned NW  = DATA_WIDTH + 2 * fpa_pkg::MaxFrac;

  logic          en;
  logic [4:0]    frac_bits_q;
  logic          fe_valid, dv_valid;
  logic [NW-1:0] fe_n, quo;
  logic [DATA_WIDTH:0] fe_d;
  fpa_pkg::ctl_t fe_ctl, dv_ctl;

  // The pipeline advances whenever the output register is free or drained.
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // Fraction size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q <= fpa_pkg::FracReset;
    end else if (cfg_we_i) begin
      frac_bits_q <= cfg_wdata_i;
    end
  end

  fpa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .a_i     (s_axis_tdata[31:0]),
    .b_i     (s_axis_tdata[63:32]),
    .frac_i  (frac_bits_q),
    .tfrac_i (s_axis_tdata[68:64]),
    .valid_o (fe_valid),
    .n_mag_o (fe_n),
    .d_mag_o (fe_d),
    .ctl_o   (fe_ctl)
  );

  fpa_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .n_i     (fe_n),
    .d_i     (fe_d),
    .ctl_i   (fe_ctl),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .ctl_o   (dv_ctl)
  );

  // Output stage: apply the sign, force zero on a zero divisor, wrap to the data width and extend to 32 bits.
  logic [DATA_WIDTH-1:0]        qlo, qsg;
  logic signed [DATA_WIDTH-1:0] res_w;
  logic                         out_v_q;
  logic [31:0]                  res_q;
  logic                         dz_q;

  always_comb begin
    qlo   = quo[DATA_WIDTH-1:0];
    qsg   = dv_ctl.neg ? DATA_WIDTH'(0) - qlo : qlo;
    res_w = dv_ctl.dz ? '0 : qsg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= 32'(res_w);
      dz_q  <= dv_ctl.dz;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = dz_q;

endmodule

`default_nettype wire

>>> rtl/fpa_checker.sv
// Port-level checker for the fixed-point arithmetic unit, bound to the top.
// Depends on fixed_point_alu_defines.svh.
`default_nettype none
`include "fixed_point_alu_defines.svh"

module fpa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cfg_we_i,
  input wire [4:0]  cfg_wdata_i,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [71:0] s_axis_tdata,
  input wire [4:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  // A stalled result transaction holds its payload.
  `FPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A zero divisor always yields a zero result.
  `FPA_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)

  // A stalled output back-pressures the input side.
  `FPA_ASSERT_IMP(a_backpressure, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

`default_nettype wire
